// File: rtl/sdds_pkg.sv
// Package for the signed decimal digit serializer.
// Holds the controller state type, command/status structs and a digit-count helper.
// No dependencies.
package sdds_pkg;

	// Default width of the signed input word.
	localparam int DEF_VALUE_WIDTH = 32;

	// Number of decimal digits needed for an unsigned magnitude of w bits.
	// The factor 1233/4096 approximates log10(2) closely enough for w up to 64.
	function automatic int digit_count(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the input word and its magnitude
		logic step;  // one shift-add-3 conversion step
		logic emit;  // advance the digit register by one digit
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;       // the captured word is negative
		logic top_zero;  // the most significant BCD digit is zero
	} status_t;

endpackage

// File: rtl/sdds_datapath.sv
// Datapath of the signed decimal digit serializer: magnitude and BCD registers.
// Performs the shift-add-3 conversion and shifts out digits on command.
// Depends on sdds_pkg.
module sdds_datapath import sdds_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  cmd_t                          cmd,
	output status_t                       status,
	output logic        [3:0]             top_digit
);

	localparam int NDIG = digit_count(VALUE_WIDTH);
	localparam int BW   = 4 * NDIG;

	logic [VALUE_WIDTH-1:0] val_u;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          bcd_adj;
	logic                   neg_q;

	assign val_u = value;

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Magnitude, sign and BCD registers; payload only, so no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= val_u[VALUE_WIDTH-1];
			mag_q <= val_u[VALUE_WIDTH-1] ? (~val_u + 1'b1) : val_u;
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (cmd.emit) begin
			bcd_q <= {bcd_q[BW-5:0], 4'd0};
		end
	end

	assign top_digit       = bcd_q[BW-1 -: 4];
	assign status.neg      = neg_q;
	assign status.top_zero = (bcd_q[BW-1 -: 4] == 4'd0);

endmodule

// File: rtl/sdds_ctrl.sv
// Controller of the signed decimal digit serializer.
// Sequences capture, conversion steps and digit emission; drives the result strobe.
// Depends on sdds_pkg.
module sdds_ctrl import sdds_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    strobe,
	output logic    is_sign,
	output logic    last
);

	localparam int NDIG = digit_count(VALUE_WIDTH);
	localparam int CMAX = (VALUE_WIDTH > NDIG) ? VALUE_WIDTH : NDIG;
	localparam int CW   = $clog2(CMAX + 1);

	state_t          state_q, state_d;
	logic   [CW-1:0] cnt_q, cnt_d;
	logic            started_q, started_d;
	logic            final_step;
	logic            final_digit;

	assign final_step  = (cnt_q == CW'(VALUE_WIDTH - 1));
	assign final_digit = (cnt_q == CW'(NDIG - 1));

	// State, counter and leading-zero flag registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			started_q <= started_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		started_d = started_q;
		cmd       = '0;
		busy      = 1'b1;
		strobe    = 1'b0;
		is_sign   = 1'b0;
		last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load  = 1'b1;
					cnt_d     = '0;
					started_d = 1'b0;
					state_d   = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				cmd.step = 1'b1;
				// The minus sign leaves during the first conversion step.
				if (cnt_q == '0 && status.neg) begin
					strobe  = 1'b1;
					is_sign = 1'b1;
				end
				if (final_step) begin
					cnt_d   = '0;
					state_d = ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				// Leading zeros are dropped, but the units digit always leaves.
				strobe = started_q || !status.top_zero || final_digit;
				last   = final_digit;
				if (!status.top_zero) begin
					started_d = 1'b1;
				end
				if (final_digit) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/signed_decimal_digit_serializer.sv
// Signed decimal digit serializer: emits a signed word as decimal symbols, MSD first.
// The sign word (if any) leaves in the cycle after start is accepted; digits follow
// after VALUE_WIDTH shift-add-3 steps. An item occupies the block through its load,
// its VALUE_WIDTH conversion steps and one emit slot per digit; no new item is taken while busy.
// Results leave one per strobe and cannot be stalled. Asynchronous active-low reset
// returns the controller to idle; the datapath registers are not reset.
module signed_decimal_digit_serializer import sdds_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          busy,
	output logic                          strobe,
	output logic                          is_sign,
	output logic        [3:0]             digit,
	output logic                          last
);

	cmd_t       cmd;
	status_t    status;
	logic [3:0] top_digit;

	sdds_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe),
		.is_sign(is_sign),
		.last   (last)
	);

	sdds_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk      (clk),
		.value    (value),
		.cmd      (cmd),
		.status   (status),
		.top_digit(top_digit)
	);

	// The sign word carries a zero digit.
	assign digit = cmd.emit ? top_digit : 4'd0;

`ifndef SYNTHESIS
	// The final word of an item releases the block on the next cycle.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !busy)
		else $error("block still busy after final word");

	// An accepted item keeps the block busy in the following cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// A sign word is never the final word of an item.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_sign |-> !last)
		else $error("sign word marked last");

	// Digit words carry a valid decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_sign |-> digit <= 4'd9)
		else $error("digit word out of range");
`endif

endmodule
